// ===== hw/rtl/window_overlap_range_search_top_defines.svh =====
// ----------------------------------------------------------------------------
// Window overlap range search: assertion macros
// Macros that wrap concurrent assertions on the top level's clock and reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_OVERLAP_RANGE_SEARCH_TOP_DEFINES_SVH
`define WINDOW_OVERLAP_RANGE_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked outside reset only.
`define WORS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wors assertion failed");
// Checked at every edge, also while reset is applied.
`define WORS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("wors assertion failed");
`else
`define WORS_ASSERT(lbl, prop)
`define WORS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/wors_pkg.sv =====
// ----------------------------------------------------------------------------
// Window overlap range search package
// Sizes, codes and the item types shared by the search block's modules.
// ----------------------------------------------------------------------------
package wors_pkg;

  localparam int MaxEntries = 64;
  localparam int EntW       = $clog2(MaxEntries);
  localparam int IdxW       = $clog2(MaxEntries + 1);
  // One search cell per halving of the interval.
  localparam int NumSteps   = IdxW;
  localparam int CntW       = 7;
  localparam int SlotW      = 6;
  localparam int PosW       = 20;
  localparam int EndW       = PosW + 1;
  localparam int AddrW      = 3;
  localparam int DataW      = 32;

  typedef enum logic {
    FuncLoad  = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  typedef enum logic {
    RegEntryCount = 1'b0
  } reg_e;

  typedef struct packed {
    func_e             func;
    logic [SlotW-1:0]  entry_index;
    logic [PosW-1:0]   entry_offset;
    logic [PosW-1:0]   entry_length;
    logic [PosW-1:0]   query_start;
    logic [PosW-1:0]   query_end;
  } req_t;

  typedef struct packed {
    logic [CntW-1:0] first_index;
    logic [CntW-1:0] past_last_index;
  } res_t;

  // State of both searches as it moves from cell to cell.
  typedef struct packed {
    logic [IdxW-1:0] first_lo;
    logic [IdxW-1:0] first_hi;
    logic [IdxW-1:0] past_lo;
    logic [IdxW-1:0] past_hi;
    logic [PosW-1:0] query_start;
    logic [PosW-1:0] query_end;
  } probe_t;

endpackage

// ===== hw/rtl/wors_table.sv =====
// ----------------------------------------------------------------------------
// Window overlap range search: span table
// Holds the spans, writes loads, launches queries and reads one end and one
// offset per cycle for the active search cell.
// ----------------------------------------------------------------------------
module wors_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      query_i,
  input  wors_pkg::req_t            req_i,
  input  logic [wors_pkg::IdxW-1:0] count_i,
  input  logic                      rd_en_i,
  input  logic [wors_pkg::EntW-1:0] end_addr_i,
  input  logic [wors_pkg::EntW-1:0] ofs_addr_i,
  output logic [wors_pkg::EndW-1:0] end_rd_o,
  output logic [wors_pkg::PosW-1:0] ofs_rd_o,
  output logic                      valid_o,
  output wors_pkg::probe_t          probe_o
);

  logic [wors_pkg::PosW-1:0] ofs_q [wors_pkg::MaxEntries];
  logic [wors_pkg::EndW-1:0] end_q [wors_pkg::MaxEntries];
  logic [wors_pkg::EntW-1:0] wr_idx;
  logic                      wr_ok;
  logic                      valid_q;
  logic [wors_pkg::EndW-1:0] end_rd_q;
  logic [wors_pkg::PosW-1:0] ofs_rd_q;
  wors_pkg::probe_t          probe_d, probe_q;

  assign wr_idx = wors_pkg::EntW'(req_i.entry_index);
  assign wr_ok  = int'(req_i.entry_index) < wors_pkg::MaxEntries;

  // Loads are taken only while no search runs, so a write never meets a read.
  always_ff @(posedge clk_i) begin
    if (load_i && wr_ok) begin
      ofs_q[wr_idx] <= req_i.entry_offset;
      end_q[wr_idx] <= {1'b0, req_i.entry_offset} + {1'b0, req_i.entry_length};
    end
    if (rd_en_i) begin
      end_rd_q <= end_q[end_addr_i];
      ofs_rd_q <= ofs_q[ofs_addr_i];
    end
  end

  always_comb begin
    probe_d             = '0;
    probe_d.first_hi    = count_i;
    probe_d.past_hi     = count_i;
    probe_d.query_start = req_i.query_start;
    probe_d.query_end   = req_i.query_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= query_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_i) begin
      probe_q <= probe_d;
    end
  end

  assign valid_o  = valid_q;
  assign probe_o  = probe_q;
  assign end_rd_o = end_rd_q;
  assign ofs_rd_o = ofs_rd_q;

endmodule

// ===== hw/rtl/wors_cell.sv =====
// ----------------------------------------------------------------------------
// Window overlap range search: search cell
// One halving step of both lower-bound searches: first the table is read at
// both midpoints, then the results are compared and registered toward the next cell.
// ----------------------------------------------------------------------------
module wors_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  wors_pkg::probe_t          probe_i,
  input  logic [wors_pkg::EndW-1:0] end_rd_i,
  input  logic [wors_pkg::PosW-1:0] ofs_rd_i,
  output logic [wors_pkg::EntW-1:0] end_addr_o,
  output logic [wors_pkg::EntW-1:0] ofs_addr_o,
  output logic                      wait_o,
  output logic                      valid_o,
  output wors_pkg::probe_t          probe_o
);

  logic [wors_pkg::IdxW-1:0] f_mid, p_mid;
  logic [wors_pkg::IdxW-1:0] f_mid_q, p_mid_q;
  logic                      wait_q, valid_q;
  wors_pkg::probe_t          hold_q;
  wors_pkg::probe_t          probe_d, probe_q;

  always_comb begin
    f_mid   = probe_i.first_lo + ((probe_i.first_hi - probe_i.first_lo) >> 1);
    p_mid   = probe_i.past_lo + ((probe_i.past_hi - probe_i.past_lo) >> 1);
    probe_d = hold_q;
    // A finished search (lo equal to hi) passes through untouched.
    if (hold_q.first_lo < hold_q.first_hi) begin
      if (end_rd_i <= {1'b0, hold_q.query_start}) begin
        probe_d.first_lo = f_mid_q + wors_pkg::IdxW'(1);
      end else begin
        probe_d.first_hi = f_mid_q;
      end
    end
    if (hold_q.past_lo < hold_q.past_hi) begin
      if (ofs_rd_i < hold_q.query_end) begin
        probe_d.past_lo = p_mid_q + wors_pkg::IdxW'(1);
      end else begin
        probe_d.past_hi = p_mid_q;
      end
    end
  end

  // Only the active cell drives a nonzero address onto the shared read port.
  assign end_addr_o = valid_i ? f_mid[wors_pkg::EntW-1:0] : '0;
  assign ofs_addr_o = valid_i ? p_mid[wors_pkg::EntW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      wait_q  <= valid_i;
      valid_q <= wait_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      hold_q  <= probe_i;
      f_mid_q <= f_mid;
      p_mid_q <= p_mid;
    end
    if (wait_q) begin
      probe_q <= probe_d;
    end
  end

  assign wait_o  = wait_q;
  assign valid_o = valid_q;
  assign probe_o = probe_q;

endmodule

// ===== hw/rtl/window_overlap_range_search_top.sv =====
// ----------------------------------------------------------------------------
// Window overlap range search: top level
// Span table with two lower-bound searches per window query.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on req_i when start_i is high and busy_o is low. A load item
//   writes one span into the table and gives no result; busy_o stays low, so
//   loads run at one item per cycle while no query is in flight.
//   A query item is registered in the table stage, then runs both searches
//   down a row of seven search cells, one halving per cell. In each cell the
//   table is first read at both midpoints, then the results are compared.
//   done_o rises once the last cell has registered its result, and res_o is
//   taken while done_o is high; the receiver cannot hold it off.
//   busy_o stays high until that result cycle ends, so one query is in flight
//   at a time; the interval between queries is set by the length of the cell
//   row and the table's registered read.
//   entry_count is written through the APB port at address 0 and saturates at
//   the table depth; write it only while the block is idle.
//   Reset clears entry_count and the in-flight item; the table contents stay
//   undefined until loaded, and queries may only probe loaded entries.
// ----------------------------------------------------------------------------
`include "window_overlap_range_search_top_defines.svh"

module window_overlap_range_search_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  wors_pkg::req_t             req_i,
  output logic                       done_o,
  output wors_pkg::res_t             res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wors_pkg::AddrW-1:0] paddr,
  input  logic [wors_pkg::DataW-1:0] pwdata,
  output logic [wors_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  logic                          accept, load, query;
  logic                          cfg_wr, cfg_sel;
  logic [wors_pkg::CntW-1:0]     count_d, count_q, wr_count;
  logic [wors_pkg::NumSteps:0]   stage_valid;
  wors_pkg::probe_t              stage_probe [wors_pkg::NumSteps+1];
  logic [wors_pkg::NumSteps-1:0] cell_wait;
  logic [wors_pkg::EntW-1:0]     cell_end_addr [wors_pkg::NumSteps];
  logic [wors_pkg::EntW-1:0]     cell_ofs_addr [wors_pkg::NumSteps];
  logic [wors_pkg::EntW-1:0]     end_addr, ofs_addr;
  logic [wors_pkg::EndW-1:0]     end_rd;
  logic [wors_pkg::PosW-1:0]     ofs_rd;
  logic                          rd_en;

  assign accept = start_i && !busy_o;
  assign load   = accept && (req_i.func == wors_pkg::FuncLoad);
  assign query  = accept && (req_i.func == wors_pkg::FuncQuery);

  // Configuration register.
  assign pready   = 1'b1;
  assign cfg_sel  = wors_pkg::reg_e'(paddr[2]) == wors_pkg::RegEntryCount;
  assign cfg_wr   = psel && penable && pwrite && cfg_sel;
  assign wr_count = pwdata[wors_pkg::CntW-1:0];

  always_comb begin
    count_d = count_q;
    if (cfg_wr) begin
      if (int'(wr_count) > wors_pkg::MaxEntries) begin
        count_d = wors_pkg::CntW'(wors_pkg::MaxEntries);
      end else begin
        count_d = wr_count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign prdata = cfg_sel ? wors_pkg::DataW'(count_q) : '0;

  // At most one cell presents an address, so the OR picks it.
  always_comb begin
    end_addr = '0;
    ofs_addr = '0;
    for (int i = 0; i < wors_pkg::NumSteps; i++) begin
      end_addr = end_addr | cell_end_addr[i];
      ofs_addr = ofs_addr | cell_ofs_addr[i];
    end
  end

  assign rd_en = |stage_valid[wors_pkg::NumSteps-1:0];

  wors_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .query_i    (query),
    .req_i      (req_i),
    .count_i    (wors_pkg::IdxW'(count_q)),
    .rd_en_i    (rd_en),
    .end_addr_i (end_addr),
    .ofs_addr_i (ofs_addr),
    .end_rd_o   (end_rd),
    .ofs_rd_o   (ofs_rd),
    .valid_o    (stage_valid[0]),
    .probe_o    (stage_probe[0])
  );

  for (genvar g = 0; g < wors_pkg::NumSteps; g++) begin : g_cell
    wors_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (stage_valid[g]),
      .probe_i    (stage_probe[g]),
      .end_rd_i   (end_rd),
      .ofs_rd_i   (ofs_rd),
      .end_addr_o (cell_end_addr[g]),
      .ofs_addr_o (cell_ofs_addr[g]),
      .wait_o     (cell_wait[g]),
      .valid_o    (stage_valid[g+1]),
      .probe_o    (stage_probe[g+1])
    );
  end

  assign busy_o                = (|stage_valid) || (|cell_wait);
  assign done_o                = stage_valid[wors_pkg::NumSteps];
  assign res_o.first_index     = wors_pkg::CntW'(stage_probe[wors_pkg::NumSteps].first_lo);
  assign res_o.past_last_index = wors_pkg::CntW'(stage_probe[wors_pkg::NumSteps].past_lo);

  `WORS_ASSERT_ALWAYS(a_pready_high, pready)
  // Only one query is ever in the table stage or the cell row.
  `WORS_ASSERT(a_one_in_flight, $onehot0({stage_valid, cell_wait}))
  `WORS_ASSERT(a_load_stays_idle, load |=> !busy_o)
  `WORS_ASSERT(a_query_goes_busy, query |=> busy_o)
  `WORS_ASSERT(a_done_after_query, done_o |-> !$past(query))

endmodule
